// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dpl_pkg.sv =====
// ----------------------------------------------------------------------------
// dpl_pkg
// Shared constants, types and state codes of the decimal period core.
// ----------------------------------------------------------------------------
`default_nettype none

package dpl_pkg;

    // sizes
    localparam int MAX_DENOMINATOR = 1024;
    localparam int ADDR_W          = $clog2(MAX_DENOMINATOR);
    localparam int DEN_W           = 10;
    localparam int STEP_W          = 10;
    localparam int EPOCH_W         = 8;
    localparam int TDATA_W         = 16;
    localparam int PROD_W          = DEN_W + 4;
    localparam int PART_W          = DEN_W + 2;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [DEN_W-1:0]   den_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [EPOCH_W-1:0] epoch_t;
    typedef logic [TDATA_W-1:0] tdata_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [PART_W-1:0]  part_t;

    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;
    localparam addr_t  ADDR_LAST   = addr_t'(MAX_DENOMINATOR - 1);

    // one table entry: item tag and step at which the remainder was first seen
    typedef struct packed {
        epoch_t epoch;
        step_t  step;
    } word_t;

    localparam int WORD_W = $bits(word_t);

    // table access request
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } mem_req_t;

    // finished result offered by the sequencer
    typedef struct packed {
        logic  valid;
        step_t length;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== src/dpl_ram.sv =====
// ----------------------------------------------------------------------------
// dpl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 18
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/dpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpl_ctrl
// Remainder sequencer: walks 1, 10 mod d, 100 mod d, ... against the table.
// ----------------------------------------------------------------------------
`default_nettype none

module dpl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire dpl_pkg::den_t     den_in,
    input  wire dpl_pkg::word_t    rd_word,
    output dpl_pkg::mem_req_t      mem_req,
    output dpl_pkg::result_t       result,
    input  wire logic              out_free
);

    dpl_pkg::state_t state_reg, state_next;
    dpl_pkg::den_t   d_reg, d_next;
    dpl_pkg::den_t   r_reg, r_next;
    dpl_pkg::step_t  step_reg, step_next;
    dpl_pkg::part_t  part_reg, part_next;
    dpl_pkg::step_t  len_reg, len_next;
    dpl_pkg::epoch_t epoch_reg, epoch_next;
    dpl_pkg::addr_t  clr_reg, clr_next;

    dpl_pkg::prod_t  prod, prod_a, prod_b, d8, d4;
    dpl_pkg::part_t  d2, d1, part_c, part_e;
    dpl_pkg::den_t   rem_new;
    dpl_pkg::step_t  step_inc;
    logic            trivial;
    logic            hit;
    logic            clr_last;

    // first half of r*10 mod d: quotient bits 8 and 4
    assign prod   = (dpl_pkg::prod_t'(r_reg) << 3) + (dpl_pkg::prod_t'(r_reg) << 1);
    assign d8     = dpl_pkg::prod_t'(d_reg) << 3;
    assign d4     = dpl_pkg::prod_t'(d_reg) << 2;
    assign prod_a = (prod >= d8) ? prod - d8 : prod;
    assign prod_b = (prod_a >= d4) ? prod_a - d4 : prod_a;

    // second half: quotient bits 2 and 1
    assign d2      = dpl_pkg::part_t'(d_reg) << 1;
    assign d1      = dpl_pkg::part_t'(d_reg);
    assign part_c  = (part_reg >= d2) ? part_reg - d2 : part_reg;
    assign part_e  = (part_c >= d1) ? part_c - d1 : part_c;
    assign rem_new = part_e[dpl_pkg::DEN_W-1:0];

    assign step_inc = step_reg + dpl_pkg::step_t'(1);
    assign hit      = (rd_word.epoch == epoch_reg);
    assign clr_last = (clr_reg == dpl_pkg::ADDR_LAST);
    assign trivial  = (den_in == '0) || (den_in == dpl_pkg::den_t'(1))
                   || (32'(den_in) >= dpl_pkg::MAX_DENOMINATOR);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpl_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = dpl_pkg::ST_IDLE;
                end
            end
            dpl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = trivial ? dpl_pkg::ST_DONE : dpl_pkg::ST_READ;
                end
            end
            dpl_pkg::ST_READ: begin
                state_next = dpl_pkg::ST_CHECK;
            end
            dpl_pkg::ST_CHECK: begin
                if (hit || rem_new == '0) begin
                    state_next = dpl_pkg::ST_DONE;
                end else begin
                    state_next = dpl_pkg::ST_READ;
                end
            end
            dpl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = (epoch_reg == dpl_pkg::EPOCH_LAST) ?
                                 dpl_pkg::ST_CLEAR : dpl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dpl_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        d_next     = d_reg;
        r_next     = r_reg;
        step_next  = step_reg;
        part_next  = part_reg;
        len_next   = len_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        case (state_reg)
            dpl_pkg::ST_CLEAR: begin
                clr_next = clr_reg + dpl_pkg::addr_t'(1);
                if (clr_last) begin
                    epoch_next = dpl_pkg::EPOCH_FIRST;
                end
            end
            dpl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    d_next    = den_in;
                    r_next    = dpl_pkg::den_t'(1);
                    step_next = '0;
                    len_next  = '0;
                end
            end
            dpl_pkg::ST_READ: begin
                part_next = prod_b[dpl_pkg::PART_W-1:0];
            end
            dpl_pkg::ST_CHECK: begin
                step_next = step_inc;
                if (hit) begin
                    len_next = step_inc - rd_word.step;
                end else begin
                    r_next = rem_new;
                end
            end
            dpl_pkg::ST_DONE: begin
                if (out_free) begin
                    clr_next = '0;
                    if (epoch_reg != dpl_pkg::EPOCH_LAST) begin
                        epoch_next = epoch_reg + dpl_pkg::epoch_t'(1);
                    end
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready              = 1'b0;
        mem_req.rd_en         = 1'b0;
        mem_req.rd_addr       = dpl_pkg::addr_t'(r_reg);
        mem_req.wr_en         = 1'b0;
        mem_req.wr_addr       = dpl_pkg::addr_t'(r_reg);
        mem_req.wr_data.epoch = epoch_reg;
        mem_req.wr_data.step  = step_inc;
        result.valid          = 1'b0;
        result.length         = len_reg;
        case (state_reg)
            dpl_pkg::ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                mem_req.wr_data = '0;
            end
            dpl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            dpl_pkg::ST_READ: begin
                mem_req.rd_en = 1'b1;
            end
            dpl_pkg::ST_CHECK: begin
                mem_req.wr_en = !hit;
            end
            dpl_pkg::ST_DONE: begin
                result.valid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpl_pkg::ST_CLEAR;
            epoch_reg <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        r_reg    <= r_next;
        step_reg <= step_next;
        part_reg <= part_next;
        len_reg  <= len_next;
    end

endmodule

`default_nettype wire

// ===== src/decimal_period_length_core.sv =====
// ----------------------------------------------------------------------------
// decimal_period_length_core
// Length of the recurring decimal cycle of 1/d, 0 when the expansion ends.
// ----------------------------------------------------------------------------
// Each remainder visited, the repeated one included (at most d of them),
// takes a read state and a check state of the first-seen table before the
// result; d of 0 or 1 goes straight to the result. Entries carry an item
// tag instead of being cleared per item. A clearing pass over all 1024
// entries runs after reset and again after every 255 items, and no word is
// accepted during it. One item is in work at a time. A finished result
// waits in the output register while the next word is accepted.
`default_nettype none

module decimal_period_length_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire dpl_pkg::tdata_t     s_tdata,   // [9:0] denominator
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output dpl_pkg::tdata_t          m_tdata    // [9:0] period_len
);

    dpl_pkg::mem_req_t mem_req;
    dpl_pkg::result_t  result;
    dpl_pkg::word_t    rd_word;
    logic              out_free;
    logic              m_valid_reg, m_valid_next;
    dpl_pkg::step_t    m_len_reg, m_len_next;

    assign out_free = !m_valid_reg || m_tready;

    dpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .den_in   (s_tdata[dpl_pkg::DEN_W-1:0]),
        .rd_word  (rd_word),
        .mem_req  (mem_req),
        .result   (result),
        .out_free (out_free)
    );

    dpl_ram #(
        .DEPTH (dpl_pkg::MAX_DENOMINATOR),
        .WIDTH (dpl_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_word)
    );

    // output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_len_next   = m_len_reg;
        if (result.valid && out_free) begin
            m_valid_next = 1'b1;
            m_len_next   = result.length;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_len_reg <= m_len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = dpl_pkg::tdata_t'(m_len_reg);

endmodule

`default_nettype wire

// ===== src/dpl_checker.sv =====
// ----------------------------------------------------------------------------
// dpl_checker
// Port-level assertions for the decimal period core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dpl_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_tvalid,
    input wire logic            s_tready,
    input wire logic            m_tvalid,
    input wire logic            m_tready,
    input wire dpl_pkg::tdata_t m_tdata
);

    // a stalled result word holds
    `ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one item in work: busy right after a word is taken
    `ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second word taken while an item is in work")

    // pad bits above the cycle length stay zero
    `ASSERT_RST(a_out_pad, aclk, aresetn, m_tvalid |-> m_tdata[15:10] == 6'd0, "nonzero pad bits in result word")

    // reset empties the output and starts the clearing pass
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid && !s_tready, "activity right after reset")

endmodule

bind decimal_period_length_core dpl_checker u_dpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream test of decimal_period_length_core: every accepted denominator word
// is run through a local period predictor, and each result word is compared
// in order against the predicted cycle length. Directed corner denominators
// come first, then random words with idle bursts on both sides, a long
// output hold-off, and a final stretch with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int CLK_HALF      = 6;
    localparam int WATCHDOG_MAX  = 25000;
    localparam int HOLD_OFF_LEN  = 3000;
    localparam int DRAIN_CYCLES  = 100;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    dpl_pkg::tdata_t s_tdata;    // [9:0] denominator
    logic            m_tvalid;
    logic            m_tready;
    dpl_pkg::tdata_t m_tdata;    // [9:0] period_len

    // predicted cycle lengths, oldest first
    dpl_pkg::step_t pending_lengths[$];
    int unsigned    mismatch_count;
    bit             quiet;
    bit             hold_off_request;
    int unsigned    hold_off_left;
    int unsigned    stall_left;
    int unsigned    idle_cycles;

    decimal_period_length_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // length of the recurring decimal cycle of 1/den, 0 if it terminates
    function automatic dpl_pkg::step_t period_of_reciprocal(input dpl_pkg::den_t den);
        bit             seen[dpl_pkg::MAX_DENOMINATOR];
        dpl_pkg::step_t first_step[dpl_pkg::MAX_DENOMINATOR];
        int unsigned    rem;
        dpl_pkg::step_t step;
        step = '0;
        if (den == '0 || int'(den) >= dpl_pkg::MAX_DENOMINATOR) begin
            return '0;
        end
        rem = 1 % int'(den);
        for (int guard = 0; guard <= dpl_pkg::MAX_DENOMINATOR; guard++) begin
            if (rem == 0) begin
                return '0;
            end
            step = step + dpl_pkg::step_t'(1);
            if (seen[rem]) begin
                return step - first_step[rem];
            end
            seen[rem]       = 1'b1;
            first_step[rem] = step;
            rem             = (rem * 10) % int'(den);
        end
        return '0;
    endfunction

    // offer one denominator word, record its predicted result on acceptance
    task automatic send_denominator(input dpl_pkg::den_t den);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dpl_pkg::tdata_t'(den);
        do @(posedge aclk); while (!s_tready);
        pending_lengths.push_back(period_of_reciprocal(den));
        @(negedge aclk);
    endtask

    // result side ready: long hold-off on request, else random stall bursts
    always @(negedge aclk) begin
        if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lengths.size() == 0) begin
                $display("%0t ERROR unexpected result word: expected none, actual %0d",
                         $time, m_tdata[dpl_pkg::STEP_W-1:0]);
                mismatch_count++;
            end else if (m_tdata[dpl_pkg::STEP_W-1:0] !== pending_lengths[0]) begin
                $display("%0t ERROR period_len: expected %0d, actual %0d",
                         $time, pending_lengths[0], m_tdata[dpl_pkg::STEP_W-1:0]);
                mismatch_count++;
                void'(pending_lengths.pop_front());
            end else begin
                void'(pending_lengths.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t ERROR watchdog: no word accepted for %0d cycles",
                     $time, WATCHDOG_MAX);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // zero, one and denominators whose expansion terminates
    task automatic test_terminating_denominators();
        dpl_pkg::den_t list[$];
        list = '{10'd0, 10'd1, 10'd2, 10'd5, 10'd10, 10'd512, 10'd625, 10'd1000};
        foreach (list[i]) send_denominator(list[i]);
    endtask

    // primes with long cycles and the largest denominator
    task automatic test_long_cycles();
        dpl_pkg::den_t list[$];
        list = '{10'd3, 10'd7, 10'd17, 10'd19, 10'd97, 10'd983, 10'd1021, 10'd1023};
        foreach (list[i]) send_denominator(list[i]);
    endtask

    // denominators, all but 99 with a pre-period before the cycle starts
    task automatic test_mixed_denominators();
        dpl_pkg::den_t list[$];
        list = '{10'd6, 10'd12, 10'd14, 10'd28, 10'd99, 10'd996};
        foreach (list[i]) send_denominator(list[i]);
    endtask

    // random denominators over the full field, weighted toward small ones
    task automatic test_random_denominators(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_denominator(dpl_pkg::den_t'($urandom_range(0, 63)));
            end else begin
                send_denominator(dpl_pkg::den_t'($urandom_range(0, 1023)));
            end
        end
    endtask

    // result side holds off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_off_request = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_denominator(dpl_pkg::den_t'($urandom_range(2, 60)));
        end
    endtask

    // back-to-back words with no idling on either side
    task automatic test_steady_stream(input int unsigned count);
        quiet = 1'b1;
        test_random_denominators(count);
    endtask

    // sequence
    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        mismatch_count   = 0;
        quiet            = 1'b0;
        hold_off_request = 1'b0;
        hold_off_left    = 0;
        stall_left       = 0;
        idle_cycles      = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_terminating_denominators();
        test_long_cycles();
        test_mixed_denominators();
        test_random_denominators(240);
        test_output_backpressure();
        test_steady_stream(20);

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        while (pending_lengths.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_lengths.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
